### hw/rtl/optmac_pkg.sv
// Shared types and constants for the outer-product tile multiply-accumulate block.
package optmac_pkg;

   // Tile geometry and accumulator format
   localparam int TILE_ROWS = 6;
   localparam int TILE_COLS = 8;
   localparam int ACC_BITS  = 48;
   localparam int B_FIELDS  = 8;
   localparam int NUM_COLS  = (TILE_COLS < B_FIELDS) ? TILE_COLS : B_FIELDS;
   localparam int SUM_BITS  = 48;
   localparam int OPND_BITS = 16;
   localparam int PROD_BITS = 2 * OPND_BITS;
   localparam int ROW_AW    = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
   localparam int ACC_ROW_BITS = NUM_COLS * ACC_BITS;

   // Field and register widths
   localparam int ROW_W      = 3;
   localparam int ROWS_W     = 3;
   localparam int COLS_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_COLS = 1'b1;
   localparam logic [ROWS_W-1:0]    ROWS_RESET      = 3'd6;
   localparam logic [COLS_W-1:0]    COLS_RESET      = 4'd8;

   typedef struct packed {
      logic signed [OPND_BITS-1:0] a_value;
      logic [ROW_W-1:0]            row_index;
      logic signed [OPND_BITS-1:0] b_col0;
      logic signed [OPND_BITS-1:0] b_col1;
      logic signed [OPND_BITS-1:0] b_col2;
      logic signed [OPND_BITS-1:0] b_col3;
      logic signed [OPND_BITS-1:0] b_col4;
      logic signed [OPND_BITS-1:0] b_col5;
      logic signed [OPND_BITS-1:0] b_col6;
      logic signed [OPND_BITS-1:0] b_col7;
      logic                        clear_first;
      logic                        last_step;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]           out_row;
      logic signed [SUM_BITS-1:0] sum0;
      logic signed [SUM_BITS-1:0] sum1;
      logic signed [SUM_BITS-1:0] sum2;
      logic signed [SUM_BITS-1:0] sum3;
      logic signed [SUM_BITS-1:0] sum4;
      logic signed [SUM_BITS-1:0] sum5;
      logic signed [SUM_BITS-1:0] sum6;
      logic signed [SUM_BITS-1:0] sum7;
      logic                       final_row;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_RUN   = 3'b001,
      ST_DRAIN = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

endpackage

### hw/rtl/optmac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module optmac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, read port returns the old contents on a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/outer_product_tile_mac.sv
// Top level of the 6x8 outer-product tile multiply-accumulate block.
// The tile of 48-bit saturating accumulators lives in one RAM, one row of eight
// accumulators per word. An accepted beat reads its row, the eight Q2.30
// products are formed in the next cycle and the saturating add follows, so the
// row is written back through the stage 1, stage 2 and write-back registers;
// forwarding from the two writes still in flight lets a new beat enter every
// clock, also to the same row. Per-row valid bits make a cleared row read as
// zero, so clear_first does not stall input and reset needs no clearing pass.
// A beat with last_step holds off input while the pipeline drains and then
// reads out one active row per cycle, while the result side takes them, through
// the RAM's single read port; input resumes once the last row has left the RAM
// output stage. Every other beat leaves input open for the next one. Result
// beats wait in an output register while new beats are taken.
module outer_product_tile_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  optmac_pkg::req_type                    req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output optmac_pkg::rsp_type                    rsp_data,
   input  logic                                   csr_wr_en,
   input  logic [optmac_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [optmac_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration
   logic [optmac_pkg::ROWS_W-1:0] rows_ff, rows_in;
   logic [optmac_pkg::COLS_W-1:0] cols_ff, cols_in;
   logic [optmac_pkg::ROWS_W-1:0] nrows;
   logic [optmac_pkg::COLS_W-1:0] ncols;

   // Control
   optmac_pkg::state_type state_ff, state_in;
   logic [optmac_pkg::ROWS_W-1:0] emit_row_ff, emit_row_in;
   logic [optmac_pkg::TILE_ROWS-1:0] valid_ff, valid_in;
   logic req_accept;
   logic row_active;
   logic row_valid;
   logic emit_valid;
   logic emit_last;
   logic emit_re;
   logic pipe_busy;
   logic [optmac_pkg::ROW_AW-1:0] req_row_addr;
   logic [optmac_pkg::ROW_AW-1:0] emit_row_addr;
   logic signed [optmac_pkg::OPND_BITS-1:0] req_b [optmac_pkg::B_FIELDS];

   // Stage 1: read data back, operands held
   logic s1_vld_ff, s1_vld_in;
   logic s1_zero_ff;
   logic s1_clr_ff;
   logic [optmac_pkg::ROW_AW-1:0] s1_row_ff;
   logic signed [optmac_pkg::OPND_BITS-1:0] s1_a_ff;
   logic signed [optmac_pkg::OPND_BITS-1:0] s1_b_ff [optmac_pkg::B_FIELDS];
   logic [optmac_pkg::ACC_ROW_BITS-1:0] s1_old;
   logic signed [optmac_pkg::PROD_BITS-1:0] s1_prod [optmac_pkg::NUM_COLS];

   // Stage 2: products and old row held
   logic s2_vld_ff, s2_vld_in;
   logic s2_clr_ff;
   logic [optmac_pkg::ROW_AW-1:0] s2_row_ff;
   logic [optmac_pkg::ACC_ROW_BITS-1:0] s2_acc_ff;
   logic signed [optmac_pkg::PROD_BITS-1:0] s2_prod_ff [optmac_pkg::NUM_COLS];
   logic [optmac_pkg::ACC_ROW_BITS-1:0] s2_old;

   // Write-back stage and a copy of the last write
   logic wb_vld_ff, wb_vld_in;
   logic [optmac_pkg::ROW_AW-1:0] wb_row_ff;
   logic [optmac_pkg::ACC_ROW_BITS-1:0] wb_data_ff, wb_data_in;
   logic lw_vld_ff, lw_vld_in;
   logic [optmac_pkg::ROW_AW-1:0] lw_row_ff;
   logic [optmac_pkg::ACC_ROW_BITS-1:0] lw_data_ff;

   // Read-out path
   logic ram_rd_en;
   logic [optmac_pkg::ROW_AW-1:0] ram_rd_addr;
   logic [optmac_pkg::ACC_ROW_BITS-1:0] ram_rd_data;
   logic e1_vld_ff, e1_vld_in;
   logic [optmac_pkg::ROWS_W-1:0] e1_row_ff;
   logic e1_zero_ff;
   logic e1_final_ff;
   logic out_ready;
   logic e1_ready;
   logic e1_adv;
   logic rsp_vld_ff, rsp_vld_in;
   optmac_pkg::rsp_type rsp_ff, rsp_in;
   logic signed [optmac_pkg::SUM_BITS-1:0] rsp_sum [optmac_pkg::B_FIELDS];

   // Clamp the register values to the tile size
   always_comb begin
      nrows = (int'(rows_ff) > optmac_pkg::TILE_ROWS) ?
              optmac_pkg::ROWS_W'(optmac_pkg::TILE_ROWS) : rows_ff;
      ncols = (int'(cols_ff) > optmac_pkg::NUM_COLS) ?
              optmac_pkg::COLS_W'(optmac_pkg::NUM_COLS) : cols_ff;
   end

   // Decode register writes
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            optmac_pkg::CSR_ACTIVE_ROWS: rows_in = csr_wdata[optmac_pkg::ROWS_W-1:0];
            optmac_pkg::CSR_ACTIVE_COLS: cols_in = csr_wdata[optmac_pkg::COLS_W-1:0];
         endcase
      end
   end

   // Input beat decode
   assign req_ready    = (state_ff == optmac_pkg::ST_RUN) && !e1_vld_ff;
   assign req_accept   = req_valid && req_ready;
   assign req_row_addr = optmac_pkg::ROW_AW'(req_data.row_index);
   assign row_active   = req_data.row_index < nrows;
   assign emit_row_addr = optmac_pkg::ROW_AW'(emit_row_ff);
   assign emit_last    = (emit_row_ff == nrows - 3'd1);
   assign pipe_busy    = s1_vld_ff || s2_vld_ff || wb_vld_ff;

   always_comb begin
      req_b[0] = req_data.b_col0;
      req_b[1] = req_data.b_col1;
      req_b[2] = req_data.b_col2;
      req_b[3] = req_data.b_col3;
      req_b[4] = req_data.b_col4;
      req_b[5] = req_data.b_col5;
      req_b[6] = req_data.b_col6;
      req_b[7] = req_data.b_col7;
   end

   // Look up the row valid bits for the input row and the read-out row
   always_comb begin
      row_valid  = 1'b0;
      emit_valid = 1'b0;
      for (int r = 0; r < optmac_pkg::TILE_ROWS; r++) begin
         if (optmac_pkg::ROW_AW'(r) == req_row_addr) begin
            row_valid = valid_ff[r];
         end
         if (optmac_pkg::ROW_AW'(r) == emit_row_addr) begin
            emit_valid = valid_ff[r];
         end
      end
   end

   // Drop all valid bits on clear, mark the row that this beat writes
   always_comb begin
      valid_in = valid_ff;
      if (req_accept) begin
         if (req_data.clear_first) begin
            valid_in = '0;
         end
         if (row_active) begin
            for (int r = 0; r < optmac_pkg::TILE_ROWS; r++) begin
               if (optmac_pkg::ROW_AW'(r) == req_row_addr) begin
                  valid_in[r] = 1'b1;
               end
            end
         end
      end
   end

   // Sequence accumulate, drain and read-out
   always_comb begin
      state_in    = state_ff;
      emit_row_in = emit_row_ff;
      emit_re     = 1'b0;
      unique case (state_ff)
         optmac_pkg::ST_RUN: begin
            if (req_accept && req_data.last_step) begin
               state_in = optmac_pkg::ST_DRAIN;
            end
         end
         optmac_pkg::ST_DRAIN: begin
            if (!pipe_busy) begin
               emit_row_in = '0;
               state_in    = (nrows == '0) ? optmac_pkg::ST_RUN : optmac_pkg::ST_EMIT;
            end
         end
         optmac_pkg::ST_EMIT: begin
            if (e1_ready) begin
               emit_re     = 1'b1;
               emit_row_in = emit_row_ff + 3'd1;
               if (emit_last) begin
                  state_in = optmac_pkg::ST_RUN;
               end
            end
         end
         default: state_in = optmac_pkg::ST_RUN;
      endcase
   end

   // Tile storage: one word per row
   assign ram_rd_en   = req_accept || emit_re;
   assign ram_rd_addr = emit_re ? emit_row_addr : req_row_addr;

   optmac_ram #(
      .WIDTH (optmac_pkg::ACC_ROW_BITS),
      .DEPTH (optmac_pkg::TILE_ROWS)
   ) u_tile_ram (
      .clock   (clock),
      .wr_en   (wb_vld_ff),
      .wr_addr (wb_row_ff),
      .wr_data (wb_data_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Stage 1: forward the writes the read missed, newest last; form products
   assign s1_vld_in = req_accept && row_active;

   always_comb begin
      s1_old = ram_rd_data;
      if (lw_vld_ff && (lw_row_ff == s1_row_ff)) begin
         s1_old = lw_data_ff;
      end
      if (wb_vld_ff && (wb_row_ff == s1_row_ff)) begin
         s1_old = wb_data_ff;
      end
      if (s1_zero_ff) begin
         s1_old = '0;
      end
      for (int c = 0; c < optmac_pkg::NUM_COLS; c++) begin
         s1_prod[c] = optmac_pkg::PROD_BITS'(s1_a_ff) * optmac_pkg::PROD_BITS'(s1_b_ff[c]);
      end
   end

   // Stage 2: forward the beat just ahead, then add and saturate
   assign s2_vld_in = s1_vld_ff;

   always_comb begin
      logic [optmac_pkg::ACC_BITS-1:0] old_c;
      logic [optmac_pkg::ACC_BITS-1:0] sat_c;
      logic [optmac_pkg::ACC_BITS:0]   sum_c;
      logic [optmac_pkg::PROD_BITS-1:0] prod_c;
      s2_old = (wb_vld_ff && (wb_row_ff == s2_row_ff) && !s2_clr_ff) ? wb_data_ff : s2_acc_ff;
      wb_data_in = s2_old;
      for (int c = 0; c < optmac_pkg::NUM_COLS; c++) begin
         old_c  = s2_old[c*optmac_pkg::ACC_BITS +: optmac_pkg::ACC_BITS];
         prod_c = s2_prod_ff[c];
         sum_c  = {old_c[optmac_pkg::ACC_BITS-1], old_c}
                + {{(optmac_pkg::ACC_BITS + 1 - optmac_pkg::PROD_BITS)
                    {prod_c[optmac_pkg::PROD_BITS-1]}}, prod_c};
         if (sum_c[optmac_pkg::ACC_BITS] != sum_c[optmac_pkg::ACC_BITS-1]) begin
            sat_c = {sum_c[optmac_pkg::ACC_BITS],
                     {(optmac_pkg::ACC_BITS-1){~sum_c[optmac_pkg::ACC_BITS]}}};
         end else begin
            sat_c = sum_c[optmac_pkg::ACC_BITS-1:0];
         end
         if (optmac_pkg::COLS_W'(c) < ncols) begin
            wb_data_in[c*optmac_pkg::ACC_BITS +: optmac_pkg::ACC_BITS] = sat_c;
         end
      end
   end

   assign wb_vld_in = s2_vld_ff;
   assign lw_vld_in = wb_vld_ff;

   // Read-out: one row in the RAM output register, one in the result register
   assign out_ready  = !rsp_vld_ff || rsp_ready;
   assign e1_ready   = !e1_vld_ff || out_ready;
   assign e1_adv     = e1_vld_ff && out_ready;
   assign e1_vld_in  = emit_re || (e1_vld_ff && !out_ready);
   assign rsp_vld_in = e1_adv || (rsp_vld_ff && !rsp_ready);

   // Zero inactive columns and rows never written since the last clear
   always_comb begin
      for (int c = 0; c < optmac_pkg::B_FIELDS; c++) begin
         rsp_sum[c] = '0;
      end
      for (int c = 0; c < optmac_pkg::NUM_COLS; c++) begin
         if ((optmac_pkg::COLS_W'(c) < ncols) && !e1_zero_ff) begin
            rsp_sum[c] = optmac_pkg::SUM_BITS'($signed(
               ram_rd_data[c*optmac_pkg::ACC_BITS +: optmac_pkg::ACC_BITS]));
         end
      end
      rsp_in.out_row   = optmac_pkg::ROW_W'(e1_row_ff);
      rsp_in.sum0      = rsp_sum[0];
      rsp_in.sum1      = rsp_sum[1];
      rsp_in.sum2      = rsp_sum[2];
      rsp_in.sum3      = rsp_sum[3];
      rsp_in.sum4      = rsp_sum[4];
      rsp_in.sum5      = rsp_sum[5];
      rsp_in.sum6      = rsp_sum[6];
      rsp_in.sum7      = rsp_sum[7];
      rsp_in.final_row = e1_final_ff;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= optmac_pkg::ROWS_RESET;
         cols_ff     <= optmac_pkg::COLS_RESET;
         state_ff    <= optmac_pkg::ST_RUN;
         emit_row_ff <= '0;
         valid_ff    <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         wb_vld_ff   <= 1'b0;
         lw_vld_ff   <= 1'b0;
         e1_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         rows_ff     <= rows_in;
         cols_ff     <= cols_in;
         state_ff    <= state_in;
         emit_row_ff <= emit_row_in;
         valid_ff    <= valid_in;
         s1_vld_ff   <= s1_vld_in;
         s2_vld_ff   <= s2_vld_in;
         wb_vld_ff   <= wb_vld_in;
         lw_vld_ff   <= lw_vld_in;
         e1_vld_ff   <= e1_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_row_ff  <= req_row_addr;
         s1_zero_ff <= req_data.clear_first || !row_valid;
         s1_clr_ff  <= req_data.clear_first;
         s1_a_ff    <= req_data.a_value;
         for (int c = 0; c < optmac_pkg::B_FIELDS; c++) begin
            s1_b_ff[c] <= req_b[c];
         end
      end
      s2_row_ff <= s1_row_ff;
      s2_clr_ff <= s1_clr_ff;
      s2_acc_ff <= s1_old;
      for (int c = 0; c < optmac_pkg::NUM_COLS; c++) begin
         s2_prod_ff[c] <= s1_prod[c];
      end
      wb_row_ff  <= s2_row_ff;
      wb_data_ff <= wb_data_in;
      lw_row_ff  <= wb_row_ff;
      lw_data_ff <= wb_data_ff;
      if (emit_re) begin
         e1_row_ff   <= emit_row_ff;
         e1_zero_ff  <= !emit_valid;
         e1_final_ff <= emit_last;
      end
      if (e1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // Read-out only starts once every pending write has landed
   a_emit_quiet: assert property (@(posedge clock) disable iff (reset)
      emit_re |-> !pipe_busy)
      else $error("tile read-out issued with writes in flight");

   // A read-out read fills the RAM output stage on the next cycle
   a_e1_load: assert property (@(posedge clock) disable iff (reset)
      emit_re |=> e1_vld_ff)
      else $error("read-out row lost after RAM read");

   // A stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result beat changed while stalled");

   // Write-back never targets a row outside the tile
   a_wb_row: assert property (@(posedge clock) disable iff (reset)
      wb_vld_ff |-> (int'(wb_row_ff) < optmac_pkg::TILE_ROWS))
      else $error("write-back row outside the tile");

endmodule

### dv/outer_product_tile_mac_tb.sv
// Self-checking testbench for the outer-product tile multiply-accumulate block.
module outer_product_tile_mac_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          B_LANES       = 8;
   localparam int          SETTLE_CYCLES = 16;
   localparam int          PHASES        = 12;
   localparam int          PHASE_BEATS   = 31;
   localparam int          SOAK_BEATS    = 8;
   localparam int unsigned CYCLE_LIMIT   = 700000;
   localparam longint      ACC_MAX       = (64'sd1 <<< (optmac_pkg::ACC_BITS - 1)) - 1;
   localparam longint      ACC_MIN       = -ACC_MAX - 1;

   typedef logic signed [optmac_pkg::SUM_BITS-1:0] sum_lanes_type [B_LANES];

   // One row of the directed script; pinned rows carry hand-computed row 0 sums
   typedef struct {
      optmac_pkg::req_type                    beat;
      bit                                     pinned;
      logic signed [optmac_pkg::SUM_BITS-1:0] even_sum;
      logic signed [optmac_pkg::SUM_BITS-1:0] odd_sum;
   } script_step_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   optmac_pkg::req_type               req_data = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   optmac_pkg::rsp_type               rsp_data;
   logic                              csr_wr_en = 1'b0;
   logic [optmac_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [optmac_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the tile, its shape registers and the rows still owed
   logic signed [optmac_pkg::ACC_BITS-1:0] tile_sums [optmac_pkg::TILE_ROWS][optmac_pkg::NUM_COLS];
   logic [optmac_pkg::ROWS_W-1:0]          rows_reg = optmac_pkg::ROWS_RESET;
   logic [optmac_pkg::COLS_W-1:0]          cols_reg = optmac_pkg::COLS_RESET;
   optmac_pkg::rsp_type                    rows_due [$];
   script_step_type                        directed_steps [$];

   int          error_count = 0;
   int unsigned cycle_count = 0;
   int          beats_sent  = 0;
   int          gap_odds    = 0;
   int          ready_hold;
   bit          tail_quiet  = 1'b0;

   outer_product_tile_mac dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("outer_product_tile_mac_tb NOT OK");
         $finish;
      end
   end

   function automatic int rows_live();
      return (rows_reg > optmac_pkg::TILE_ROWS) ? optmac_pkg::TILE_ROWS : int'(rows_reg);
   endfunction

   function automatic int cols_live();
      return (cols_reg > optmac_pkg::NUM_COLS) ? optmac_pkg::NUM_COLS : int'(cols_reg);
   endfunction

   function automatic optmac_pkg::rsp_type pack_row(input int row, input sum_lanes_type s,
                                                    input bit last_one);
      return optmac_pkg::rsp_type'({3'(row), s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7],
                                    last_one});
   endfunction

   function automatic logic signed [optmac_pkg::SUM_BITS-1:0] col_sum(
      input optmac_pkg::rsp_type r, input int c);
      case (c)
         0: return r.sum0;
         1: return r.sum1;
         2: return r.sum2;
         3: return r.sum3;
         4: return r.sum4;
         5: return r.sum5;
         6: return r.sum6;
         7: return r.sum7;
         default: return '0;
      endcase
   endfunction

   // Saturating add of one exact Q2.30 product into a Q18.30 accumulator
   function automatic logic signed [optmac_pkg::ACC_BITS-1:0] sat_accumulate(
      input logic signed [optmac_pkg::ACC_BITS-1:0] acc, input logic signed [31:0] prod);
      longint total;
      total = longint'(acc) + longint'(prod);
      if (total > ACC_MAX) return optmac_pkg::ACC_BITS'(ACC_MAX);
      if (total < ACC_MIN) return optmac_pkg::ACC_BITS'(ACC_MIN);
      return total[optmac_pkg::ACC_BITS-1:0];
   endfunction

   // Apply one accepted beat to the shadow tile and queue the rows it emits
   function automatic void accumulate_beat(input optmac_pkg::req_type beat);
      logic signed [optmac_pkg::OPND_BITS-1:0] lane [B_LANES];
      logic signed [31:0]                      prod;
      sum_lanes_type                           s;
      int                                      nr;
      int                                      nc;
      nr = rows_live();
      nc = cols_live();
      lane = '{beat.b_col0, beat.b_col1, beat.b_col2, beat.b_col3,
               beat.b_col4, beat.b_col5, beat.b_col6, beat.b_col7};
      if (beat.clear_first) begin
         foreach (tile_sums[r, c]) tile_sums[r][c] = '0;
      end
      if (beat.row_index < nr) begin
         for (int c = 0; c < nc; c++) begin
            prod = $signed(beat.a_value) * $signed(lane[c]);
            tile_sums[beat.row_index][c] = sat_accumulate(tile_sums[beat.row_index][c], prod);
         end
      end
      if (beat.last_step) begin
         for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < B_LANES; c++) s[c] = (c < nc) ? tile_sums[r][c] : '0;
            rows_due.push_back(pack_row(r, s, r + 1 == nr));
         end
      end
   endfunction

   // Replace the row 0 expectation of the latest tile with hand-computed sums
   function automatic void pin_row0(input longint even_sum, input longint odd_sum);
      sum_lanes_type       s;
      optmac_pkg::rsp_type r;
      int                  first;
      first = rows_due.size() - rows_live();
      r = rows_due[first];
      for (int c = 0; c < B_LANES; c++) begin
         if (c >= cols_live()) s[c] = '0;
         else s[c] = (c % 2 == 0) ? optmac_pkg::SUM_BITS'(even_sum)
                                  : optmac_pkg::SUM_BITS'(odd_sum);
      end
      rows_due[first] = pack_row(r.out_row, s, r.final_row);
   endfunction

   function automatic optmac_pkg::req_type make_beat(input int a, input int row,
                                                     input int b_even, input int b_odd,
                                                     input bit clr, input bit lst);
      optmac_pkg::req_type b;
      b.a_value     = 16'(a);
      b.row_index   = 3'(row);
      b.b_col0      = 16'(b_even);
      b.b_col1      = 16'(b_odd);
      b.b_col2      = 16'(b_even);
      b.b_col3      = 16'(b_odd);
      b.b_col4      = 16'(b_even);
      b.b_col5      = 16'(b_odd);
      b.b_col6      = 16'(b_even);
      b.b_col7      = 16'(b_odd);
      b.clear_first = clr;
      b.last_step   = lst;
      return b;
   endfunction

   function automatic void add_step(input optmac_pkg::req_type beat, input bit pinned,
                                    input longint even_sum, input longint odd_sum);
      script_step_type st;
      st.beat     = beat;
      st.pinned   = pinned;
      st.even_sum = optmac_pkg::SUM_BITS'(even_sum);
      st.odd_sum  = optmac_pkg::SUM_BITS'(odd_sum);
      directed_steps.push_back(st);
   endfunction

   // Favor the operand rails now and then
   function automatic logic signed [optmac_pkg::OPND_BITS-1:0] rand_operand();
      case ($urandom_range(0, 11))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         3: return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic optmac_pkg::req_type random_beat();
      optmac_pkg::req_type b;
      b.a_value     = rand_operand();
      b.row_index   = 3'($urandom_range(0, 7));
      b.b_col0      = rand_operand();
      b.b_col1      = rand_operand();
      b.b_col2      = rand_operand();
      b.b_col3      = rand_operand();
      b.b_col4      = rand_operand();
      b.b_col5      = rand_operand();
      b.b_col6      = rand_operand();
      b.b_col7      = rand_operand();
      b.clear_first = ($urandom_range(0, 5) == 0);
      b.last_step   = ($urandom_range(0, 4) == 0);
      return b;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Drive one beat from a falling edge and hold it until accepted
   task automatic send_beat(input optmac_pkg::req_type beat);
      if (!tail_quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_data  = beat;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accumulate_beat(beat);
      beats_sent++;
      @(negedge clock);
   endtask

   // Drop valid, drain every owed row, then let the pipeline empty
   task automatic settle();
      req_valid = 1'b0;
      while (rows_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [optmac_pkg::CSR_IDX_W-1:0] idx,
                            input logic [optmac_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == optmac_pkg::CSR_ACTIVE_ROWS) rows_reg = value[optmac_pkg::ROWS_W-1:0];
      else cols_reg = value[optmac_pkg::COLS_W-1:0];
   endtask

   task automatic set_shape(input logic [optmac_pkg::CSR_DATA_W-1:0] rows,
                            input logic [optmac_pkg::CSR_DATA_W-1:0] cols);
      settle();
      write_reg(optmac_pkg::CSR_ACTIVE_ROWS, rows);
      write_reg(optmac_pkg::CSR_ACTIVE_COLS, cols);
   endtask

   // One well-formed tile: clear on the first k step, emit on the last
   task automatic send_tile();
      optmac_pkg::req_type beat;
      int                  depth;
      int                  nr;
      depth = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
      nr = rows_live();
      for (int k = 0; k < depth; k++) begin
         beat = random_beat();
         if (nr != 0 && $urandom_range(0, 7) != 0) beat.row_index = 3'($urandom_range(0, nr - 1));
         beat.clear_first = (k == 0);
         beat.last_step   = (k == depth - 1);
         send_beat(beat);
      end
   endtask

   // Result side stalls in bursts, never in the tail
   always begin
      @(negedge clock);
      if (tail_quiet || $urandom_range(0, 2) != 0) begin
         rsp_ready  = 1'b1;
         ready_hold = $urandom_range(1, 20);
      end else begin
         rsp_ready  = 1'b0;
         ready_hold = $urandom_range(1, 13);
      end
      repeat (ready_hold - 1) @(negedge clock);
   end

   // Check each result beat against the oldest owed row
   always @(posedge clock) begin
      optmac_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rows_due.size() == 0) begin
            report_mismatch($sformatf("row %0d emitted with nothing owed", rsp_data.out_row));
         end else begin
            want = rows_due.pop_front();
            if (rsp_data.out_row !== want.out_row)
               report_mismatch($sformatf("out_row %0d, want %0d", rsp_data.out_row, want.out_row));
            for (int c = 0; c < B_LANES; c++) begin
               if (col_sum(rsp_data, c) !== col_sum(want, c))
                  report_mismatch($sformatf("row %0d sum%0d %0d, want %0d", want.out_row, c,
                                            col_sum(rsp_data, c), col_sum(want, c)));
            end
            if (rsp_data.final_row !== want.final_row)
               report_mismatch($sformatf("row %0d final_row %0b, want %0b", want.out_row,
                                         rsp_data.final_row, want.final_row));
         end
      end
   end

   initial begin
      optmac_pkg::req_type               beat;
      logic [optmac_pkg::CSR_DATA_W-1:0] shape_rows [8];
      logic [optmac_pkg::CSR_DATA_W-1:0] shape_cols [8];
      int                                phase_start;

      shape_rows = '{4'd1, 4'd6, 4'd0, 4'd7, 4'd3, 4'd14, 4'd2, 4'd5};
      shape_cols = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd3, 4'd9, 4'd7};
      foreach (tile_sums[r, c]) tile_sums[r][c] = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed script under the reset shape
      add_step(make_beat(0, 0, 32767, -1, 0, 1), 1, 0, 0);
      add_step(make_beat(-32768, 0, -32768, 32767, 1, 1), 1, 1073741824, -1073709056);
      add_step(make_beat(32767, 0, 32767, -32768, 1, 0), 0, 0, 0);
      add_step(make_beat(-1, 0, -1, 1, 0, 1), 1, 1073676290, -1073709057);
      add_step(make_beat(12345, 5, -32768, 32767, 0, 1), 0, 0, 0);
      add_step(make_beat(32767, 6, 32767, 32767, 0, 1), 0, 0, 0);
      add_step(make_beat(-32768, 7, -32768, -32768, 0, 0), 0, 0, 0);
      add_step(make_beat(100, 3, 200, -300, 1, 1), 1, 0, 0);
      add_step(make_beat(-20000, 1, 30000, -7, 0, 0), 0, 0, 0);
      add_step(make_beat(31000, 2, -31000, 1, 0, 0), 0, 0, 0);
      add_step(make_beat(-32768, 4, 0, -32768, 0, 0), 0, 0, 0);
      add_step(make_beat(16'h5555, 1, 16'hAAAA, 16'h5555, 0, 0), 0, 0, 0);
      add_step(make_beat(1, 5, -1, 32767, 0, 1), 0, 0, 0);
      add_step(make_beat(0, 7, 0, 0, 1, 1), 1, 0, 0);
      add_step(make_beat(2, 0, 3, 4, 0, 1), 1, 6, 8);

      gap_odds = 3;
      foreach (directed_steps[i]) begin
         send_beat(directed_steps[i].beat);
         if (directed_steps[i].pinned) pin_row0(directed_steps[i].even_sum, directed_steps[i].odd_sum);
      end

      // Stack full-scale products on row 0 back to back: even lanes climb, odd lanes fall
      settle();
      gap_odds = 0;
      beat = make_beat(-32768, 0, -32768, 32767, 1, 0);
      send_beat(beat);
      beat.clear_first = 1'b0;
      repeat (SOAK_BEATS) send_beat(beat);
      send_beat(make_beat(0, 0, 0, 0, 0, 1));
      send_beat(make_beat(-32768, 0, 32767, -32768, 0, 1));

      // Random phases, each under its own tile shape
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 8) set_shape(shape_rows[phase], shape_cols[phase]);
         else set_shape(4'($urandom_range(1, 6)), 4'($urandom_range(1, 8)));
         tail_quiet = (phase >= PHASES - 2);
         case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 2;
            default: gap_odds = 5;
         endcase
         phase_start = beats_sent;
         while (beats_sent - phase_start < PHASE_BEATS) begin
            if ($urandom_range(0, 24) == 0) settle();
            if ($urandom_range(0, 4) == 0) send_beat(random_beat());
            else send_tile();
         end
      end

      req_valid = 1'b0;
      while (rows_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("outer_product_tile_mac_tb OK");
      end else begin
         $display("outer_product_tile_mac_tb NOT OK");
      end
      $finish;
   end

endmodule

### outer_product_tile_mac.f
hw/rtl/optmac_pkg.sv
hw/rtl/optmac_ram.sv
hw/rtl/outer_product_tile_mac.sv
dv/outer_product_tile_mac_tb.sv
